@@ src/hsv_palette_to_rgb_assert.svh @@
// ----------------------------------------------------------------------------
// HSV palette converter assertion macros
// Clocked property checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef HSV_PALETTE_TO_RGB_ASSERT_SVH
`define HSV_PALETTE_TO_RGB_ASSERT_SVH

`ifndef SYNTHESIS
// check that holds outside reset
`define HSVP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hsvp check failed");
// check that also holds across reset
`define HSVP_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("hsvp reset check failed");
`else
`define HSVP_ASSERT(lbl, prop)
`define HSVP_ASSERT_RST(lbl, prop)
`endif

`endif

@@ src/hsvp_pkg.sv @@
// ----------------------------------------------------------------------------
// hsvp_pkg
// Shared types and fixed-point constants of the HSV palette converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvp_pkg;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_ACCENT = 2'd1,
        MODE_BELLY  = 2'd2,
        MODE_EYE    = 2'd3
    } t_mode;

    // palette constants in units of 1/255
    localparam logic [7:0] ACC_SAT_ADD = 8'd38;
    localparam logic [7:0] ACC_SAT_MAX = 8'd230;
    localparam logic [7:0] ACC_VAL_SUB = 8'd51;
    localparam logic [7:0] ACC_VAL_MIN = 8'd64;
    localparam logic [7:0] BEL_SAT_SUB = 8'd64;
    localparam logic [7:0] BEL_SAT_MIN = 8'd38;
    localparam logic [7:0] BEL_VAL_ADD = 8'd46;
    localparam logic [7:0] BEL_VAL_MAX = 8'd242;
    localparam logic [7:0] EYE_VAL_THR = 8'd153;
    localparam logic [7:0] EYE_HI_SAT  = 8'd77;
    localparam logic [7:0] EYE_HI_VAL  = 8'd20;
    localparam logic [7:0] EYE_LO_SAT  = 8'd13;
    localparam logic [7:0] EYE_LO_VAL  = 8'd242;
    localparam logic [15:0] HALF_TURN  = 16'h8000;

    // 1.0 as 255 * 2^16, half of it for rounding
    localparam logic [23:0] UNIT_FULL  = 24'd16711680;
    localparam logic [32:0] UNIT_HALF  = 33'd8355840;
    // floor(x/255) = (x * 32897) >> 23 for x < 2^16
    localparam logic [15:0] RECIP_255  = 16'd32897;
    // (vs*2^16 + UNIT_HALF) >> 16 == vs + 127
    localparam logic [16:0] P_ROUND    = 17'd127;

    typedef struct packed {
        logic [2:0]  sector;
        logic [15:0] frac;
        logic [7:0]  sat;
        logic [7:0]  val;
    } t_sect;

    typedef struct packed {
        logic [2:0] sector;
        logic [7:0] val;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
    } t_chan;

endpackage

`default_nettype wire

@@ src/hsvp_adjust.sv @@
// ----------------------------------------------------------------------------
// hsvp_adjust
// Palette rule on H, S, V, then hue sector split. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvp_adjust (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_func,
    input  wire logic [15:0]   i_hue,
    input  wire logic [15:0]   i_hue_shift,
    input  wire logic [7:0]    i_saturation,
    input  wire logic [7:0]    i_brightness,
    output logic               o_valid,
    input  wire logic          i_ready,
    output hsvp_pkg::t_sect    o_sect
);
    import hsvp_pkg::*;

    logic        r_s1_vld;
    logic [15:0] r_s1_hue;
    logic [7:0]  r_s1_sat;
    logic [7:0]  r_s1_val;
    logic        r_s2_vld;
    t_sect       r_s2_sect;

    logic        w_s1_rdy;
    logic        w_s2_rdy;
    logic [15:0] n_s1_hue;
    logic [7:0]  n_s1_sat;
    logic [7:0]  n_s1_val;
    logic [8:0]  w_sat_up;
    logic [8:0]  w_val_up;
    logic [18:0] w_h6;

    assign w_s2_rdy = !r_s2_vld || i_ready;
    assign w_s1_rdy = !r_s1_vld || w_s2_rdy;
    assign o_ready  = w_s1_rdy;

    assign w_sat_up = {1'b0, i_saturation} + {1'b0, ACC_SAT_ADD};
    assign w_val_up = {1'b0, i_brightness} + {1'b0, BEL_VAL_ADD};

    always_comb begin
        n_s1_hue = i_hue;
        n_s1_sat = i_saturation;
        n_s1_val = i_brightness;
        case (t_mode'(i_func))
            MODE_ACCENT: begin
                n_s1_hue = i_hue + i_hue_shift;
                n_s1_sat = (w_sat_up > {1'b0, ACC_SAT_MAX}) ? ACC_SAT_MAX : w_sat_up[7:0];
                n_s1_val = (i_brightness < (ACC_VAL_SUB + ACC_VAL_MIN)) ?
                           ACC_VAL_MIN : (i_brightness - ACC_VAL_SUB);
            end
            MODE_BELLY: begin
                n_s1_sat = (i_saturation < (BEL_SAT_SUB + BEL_SAT_MIN)) ?
                           BEL_SAT_MIN : (i_saturation - BEL_SAT_SUB);
                n_s1_val = (w_val_up > {1'b0, BEL_VAL_MAX}) ? BEL_VAL_MAX : w_val_up[7:0];
            end
            MODE_EYE: begin
                n_s1_hue = i_hue + HALF_TURN;
                n_s1_sat = (i_brightness > EYE_VAL_THR) ? EYE_HI_SAT : EYE_LO_SAT;
                n_s1_val = (i_brightness > EYE_VAL_THR) ? EYE_HI_VAL : EYE_LO_VAL;
            end
            default: begin
                n_s1_hue = i_hue;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_s1_rdy) begin
            r_s1_vld <= i_valid;
            if (i_valid) begin
                r_s1_hue <= n_s1_hue;
                r_s1_sat <= n_s1_sat;
                r_s1_val <= n_s1_val;
            end
        end
    end

    // H*6: top three bits pick the sector, the rest is the fraction
    assign w_h6 = {3'b000, r_s1_hue} * 19'd6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_s2_rdy) begin
            r_s2_vld <= r_s1_vld;
            if (r_s1_vld) begin
                r_s2_sect.sector <= w_h6[18:16];
                r_s2_sect.frac   <= w_h6[15:0];
                r_s2_sect.sat    <= r_s1_sat;
                r_s2_sect.val    <= r_s1_val;
            end
        end
    end

    assign o_valid = r_s2_vld;
    assign o_sect  = r_s2_sect;

endmodule

`default_nettype wire

@@ src/hsvp_scale.sv @@
// ----------------------------------------------------------------------------
// hsvp_scale
// Computes p, q and t with rounding to 8 bits. Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvp_scale (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  hsvp_pkg::t_sect    i_sect,
    output logic               o_valid,
    input  wire logic          i_ready,
    output hsvp_pkg::t_chan    o_chan
);
    import hsvp_pkg::*;

    // stage 3: products with S
    logic        r_s3_vld;
    logic [2:0]  r_s3_sector;
    logic [7:0]  r_s3_val;
    logic [23:0] r_s3_fs;
    logic [24:0] r_s3_fcs;
    logic [15:0] r_s3_vs;
    // stage 4: 1 - x terms
    logic        r_s4_vld;
    logic [2:0]  r_s4_sector;
    logic [7:0]  r_s4_val;
    logic [23:0] r_s4_a;
    logic [23:0] r_s4_b;
    logic [16:0] r_s4_mp;
    // stage 5: scaled by V, rounded, shifted
    logic        r_s5_vld;
    logic [2:0]  r_s5_sector;
    logic [7:0]  r_s5_val;
    logic [16:0] r_s5_mp;
    logic [16:0] r_s5_mq;
    logic [16:0] r_s5_mt;
    // stage 6: divided by 255
    logic        r_s6_vld;
    t_chan       r_s6_chan;

    logic        w_s3_rdy;
    logic        w_s4_rdy;
    logic        w_s5_rdy;
    logic        w_s6_rdy;
    logic [24:0] w_fcs_sub;
    logic [32:0] w_nq;
    logic [32:0] w_nt;
    logic [32:0] w_dp;
    logic [32:0] w_dq;
    logic [32:0] w_dt;

    assign w_s6_rdy = !r_s6_vld || i_ready;
    assign w_s5_rdy = !r_s5_vld || w_s6_rdy;
    assign w_s4_rdy = !r_s4_vld || w_s5_rdy;
    assign w_s3_rdy = !r_s3_vld || w_s4_rdy;
    assign o_ready  = w_s3_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_s3_rdy) begin
            r_s3_vld <= i_valid;
            if (i_valid) begin
                r_s3_sector <= i_sect.sector;
                r_s3_val    <= i_sect.val;
                r_s3_fs     <= {8'd0, i_sect.frac} * {16'd0, i_sect.sat};
                r_s3_fcs    <= (25'h10000 - {9'd0, i_sect.frac}) * {17'd0, i_sect.sat};
                r_s3_vs     <= {8'd0, i_sect.val} * {8'd0, 8'd255 - i_sect.sat};
            end
        end
    end

    assign w_fcs_sub = {1'b0, UNIT_FULL} - r_s3_fcs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (w_s4_rdy) begin
            r_s4_vld <= r_s3_vld;
            if (r_s3_vld) begin
                r_s4_sector <= r_s3_sector;
                r_s4_val    <= r_s3_val;
                r_s4_a      <= UNIT_FULL - r_s3_fs;
                r_s4_b      <= w_fcs_sub[23:0];
                r_s4_mp     <= {1'b0, r_s3_vs} + P_ROUND;
            end
        end
    end

    // V * (1 - x) + half unit fits 32 bits; keep 33 for headroom
    assign w_nq = ({25'd0, r_s4_val} * {9'd0, r_s4_a}) + UNIT_HALF;
    assign w_nt = ({25'd0, r_s4_val} * {9'd0, r_s4_b}) + UNIT_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (w_s5_rdy) begin
            r_s5_vld <= r_s4_vld;
            if (r_s4_vld) begin
                r_s5_sector <= r_s4_sector;
                r_s5_val    <= r_s4_val;
                r_s5_mp     <= r_s4_mp;
                r_s5_mq     <= w_nq[32:16];
                r_s5_mt     <= w_nt[32:16];
            end
        end
    end

    assign w_dp = {16'd0, r_s5_mp} * {17'd0, RECIP_255};
    assign w_dq = {16'd0, r_s5_mq} * {17'd0, RECIP_255};
    assign w_dt = {16'd0, r_s5_mt} * {17'd0, RECIP_255};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else if (w_s6_rdy) begin
            r_s6_vld <= r_s5_vld;
            if (r_s5_vld) begin
                r_s6_chan.sector <= r_s5_sector;
                r_s6_chan.val    <= r_s5_val;
                r_s6_chan.p      <= w_dp[30:23];
                r_s6_chan.q      <= w_dq[30:23];
                r_s6_chan.t      <= w_dt[30:23];
            end
        end
    end

    assign o_valid = r_s6_vld;
    assign o_chan  = r_s6_chan;

endmodule

`default_nettype wire

@@ src/hsv_palette_to_rgb.sv @@
// ----------------------------------------------------------------------------
// hsv_palette_to_rgb
// Palette-adjusted HSV to 8-bit RGB converter, seven-stage pipeline.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  input   | i_valid / o_ready   | i_func, i_hue, i_hue_shift, i_saturation,
//          |                     | i_brightness
//  output  | o_valid / i_ready   | o_red, o_green, o_blue
//
//  Takes one item per cycle while i_ready does not stall the output.
//  Stages: mode adjust, hue sector split, products with S, 1 - x terms,
//  scale by V with rounding, divide by 255, sector select into the output.
//  Each stage holds its item while the next is full, so a stall at i_ready
//  backs up stage by stage and no item is lost or repeated.
//  Synchronous active-low reset empties every stage; payload is not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hsv_palette_to_rgb_assert.svh"

module hsv_palette_to_rgb (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [15:0] i_hue,
    input  wire logic [15:0] i_hue_shift,
    input  wire logic [7:0]  i_saturation,
    input  wire logic [7:0]  i_brightness,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue
);
    import hsvp_pkg::*;

    logic       w_adj_vld;
    logic       w_adj_rdy;
    t_sect      w_sect;
    logic       w_scl_vld;
    logic       w_scl_rdy;
    t_chan      w_chan;

    logic       r_out_vld;
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;
    logic [7:0] n_red;
    logic [7:0] n_green;
    logic [7:0] n_blue;

    // stages 1-2: palette rule and hue sector
    hsvp_adjust u_adjust (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_hue        (i_hue),
        .i_hue_shift  (i_hue_shift),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (w_adj_vld),
        .i_ready      (w_adj_rdy),
        .o_sect       (w_sect)
    );

    // stages 3-6: p, q, t
    hsvp_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_adj_vld),
        .o_ready (w_adj_rdy),
        .i_sect  (w_sect),
        .o_valid (w_scl_vld),
        .i_ready (w_scl_rdy),
        .o_chan  (w_chan)
    );

    // stage 7: route V, p, q, t by sector; the output register is the last stage
    assign w_scl_rdy = !r_out_vld || i_ready;

    always_comb begin
        case (w_chan.sector)
            3'd0: begin
                n_red = w_chan.val; n_green = w_chan.t;   n_blue = w_chan.p;
            end
            3'd1: begin
                n_red = w_chan.q;   n_green = w_chan.val; n_blue = w_chan.p;
            end
            3'd2: begin
                n_red = w_chan.p;   n_green = w_chan.val; n_blue = w_chan.t;
            end
            3'd3: begin
                n_red = w_chan.p;   n_green = w_chan.q;   n_blue = w_chan.val;
            end
            3'd4: begin
                n_red = w_chan.t;   n_green = w_chan.p;   n_blue = w_chan.val;
            end
            default: begin
                n_red = w_chan.val; n_green = w_chan.p;   n_blue = w_chan.q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_scl_rdy) begin
            r_out_vld <= w_scl_vld;
            if (w_scl_vld) begin
                r_red   <= n_red;
                r_green <= n_green;
                r_blue  <= n_blue;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // empty output stage means the whole ready chain is open
    `HSVP_ASSERT(a_empty_takes_input, !r_out_vld |-> o_ready)
    // reset drains the output stage
    `HSVP_ASSERT_RST(a_reset_empties, !i_rst_n |=> !r_out_vld)
    // item waiting behind a stalled output stays put
    `HSVP_ASSERT(a_s6_holds_vld, r_out_vld && !i_ready && w_scl_vld |=> w_scl_vld)
    `HSVP_ASSERT(a_s6_holds_data, r_out_vld && !i_ready && w_scl_vld |=> $stable(w_chan))

endmodule

`default_nettype wire

@@ dv/hsv_palette_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_palette_checker
// Watches both channels of the palette converter, predicts the RGB triple of
// every accepted item and compares it, field by field, with the results in
// order.
// ----------------------------------------------------------------------------
module hsv_palette_checker
    import hsvp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [15:0] i_hue,
    input  wire logic [15:0] i_hue_shift,
    input  wire logic [7:0]  i_saturation,
    input  wire logic [7:0]  i_brightness,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam longint unsigned UNIT = 64'd16711680; // 1.0 as 255 * 2^16

    t_rgb rgb_q[$];
    int   fail_cnt    = 0;
    int   pending_cnt = 0;
    int   checked_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;
    assign o_checked    = checked_cnt;

    // palette rule, then six-sector HSV conversion with exact rounding
    function automatic t_rgb palette_rgb(t_mode mode, logic [15:0] hue,
                                         logic [15:0] shift, logic [7:0] sat,
                                         logic [7:0] val);
        logic [15:0]     h;
        logic [18:0]     h6;
        int              s;
        int              v;
        longint unsigned f;
        longint unsigned ls;
        longint unsigned lv;
        longint unsigned pv;
        longint unsigned qv;
        longint unsigned tv;
        t_rgb            rgb;
        h = hue;
        s = int'(sat);
        v = int'(val);
        case (mode)
            MODE_ACCENT: begin
                h = hue + shift;
                s = int'(sat) + int'(ACC_SAT_ADD);
                if (s > int'(ACC_SAT_MAX)) s = int'(ACC_SAT_MAX);
                v = int'(val) - int'(ACC_VAL_SUB);
                if (v < int'(ACC_VAL_MIN)) v = int'(ACC_VAL_MIN);
            end
            MODE_BELLY: begin
                s = int'(sat) - int'(BEL_SAT_SUB);
                if (s < int'(BEL_SAT_MIN)) s = int'(BEL_SAT_MIN);
                v = int'(val) + int'(BEL_VAL_ADD);
                if (v > int'(BEL_VAL_MAX)) v = int'(BEL_VAL_MAX);
            end
            MODE_EYE: begin
                h = hue + HALF_TURN;
                if (val > EYE_VAL_THR) begin
                    s = int'(EYE_HI_SAT);
                    v = int'(EYE_HI_VAL);
                end else begin
                    s = int'(EYE_LO_SAT);
                    v = int'(EYE_LO_VAL);
                end
            end
            default: ;
        endcase
        h6 = {3'b000, h} * 19'd6;
        f  = h6[15:0];
        ls = s;
        lv = v;
        pv = (lv * (255 - ls) * 65536 + UNIT / 2) / UNIT;
        qv = (lv * (UNIT - f * ls) + UNIT / 2) / UNIT;
        tv = (lv * (UNIT - (65536 - f) * ls) + UNIT / 2) / UNIT;
        case (h6[18:16])
            3'd0:    rgb = '{lv[7:0], tv[7:0], pv[7:0]};
            3'd1:    rgb = '{qv[7:0], lv[7:0], pv[7:0]};
            3'd2:    rgb = '{pv[7:0], lv[7:0], tv[7:0]};
            3'd3:    rgb = '{pv[7:0], qv[7:0], lv[7:0]};
            3'd4:    rgb = '{tv[7:0], pv[7:0], lv[7:0]};
            default: rgb = '{lv[7:0], pv[7:0], qv[7:0]};
        endcase
        return rgb;
    endfunction

    task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rgb want;
        if (i_rst_n) begin
            // results first: a result can never belong to an item taken this edge
            if (i_out_valid && i_out_ready) begin
                if (rgb_q.size() == 0) begin
                    $error("unexpected result r=%0d g=%0d b=%0d", i_red, i_green, i_blue);
                    fail_cnt++;
                end else begin
                    want = rgb_q.pop_front();
                    checked_cnt++;
                    check_channel("red", want.red, i_red);
                    check_channel("green", want.green, i_green);
                    check_channel("blue", want.blue, i_blue);
                end
            end
            if (i_in_valid && i_in_ready) begin
                rgb_q.push_back(palette_rgb(t_mode'(i_func), i_hue, i_hue_shift,
                                            i_saturation, i_brightness));
            end
            pending_cnt = rgb_q.size();
        end
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Palette converter testbench: directed corner colours, then random colours
// under random back-pressure, a long output stall and a full drain pause.
// Prediction and comparison live in hsv_palette_checker.
// ----------------------------------------------------------------------------
module tb;
    import hsvp_pkg::*;

    localparam int DRAIN_CYCLES = 20;   // well past the depth of the seven-stage pipeline
    localparam int HOLD_CYCLES  = 150;  // long receiver stall
    localparam int SECTOR_STEP  = 10923; // about one sixth of a turn in Q0.16

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_ready;
    logic [1:0]  i_func       = '0;
    logic [15:0] i_hue        = '0;
    logic [15:0] i_hue_shift  = '0;
    logic [7:0]  i_saturation = '0;
    logic [7:0]  i_brightness = '0;
    logic        o_valid;
    logic        i_ready      = 1'b0;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;

    int fail_count;
    int pending;
    int checked;

    // item taken at the last rising edge, read by the driver at the falling one
    logic item_taken = 1'b0;
    // stimulus controls; quiet and rx_hold are shared with the receiver process
    bit   quiet      = 1'b0;  // no idling on either side
    bit   rx_hold    = 1'b0;  // ask the receiver for one long stall
    bit   tx_gaps_on = 1'b1;
    int   mode_cnt[4];

    hsv_palette_to_rgb u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_hue        (i_hue),
        .i_hue_shift  (i_hue_shift),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    hsv_palette_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_func       (i_func),
        .i_hue        (i_hue),
        .i_hue_shift  (i_hue_shift),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_red        (o_red),
        .i_green      (o_green),
        .i_blue       (o_blue),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        item_taken <= i_valid && o_ready;
    end

    // Receiver: runs of ready, short stall bursts, and one long stall on request.
    // The long stall is counted here so the sender keeps offering meanwhile.
    initial begin : receiver
        int run_len;
        @(negedge i_clk);
        forever begin
            if (rx_hold) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                rx_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
                run_len = $urandom_range(1, 40);
                repeat (run_len) begin
                    @(negedge i_clk);
                    if (rx_hold) break;
                end
            end
        end
    end

    // Offer one item at a falling edge and hold it until taken. Returns at the
    // falling edge after acceptance, so a following item keeps valid high.
    task automatic send_colour(t_mode mode, logic [15:0] hue, logic [15:0] shift,
                               logic [7:0] sat, logic [7:0] val);
        if (!quiet && tx_gaps_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= mode;
        i_hue        <= hue;
        i_hue_shift  <= shift;
        i_saturation <= sat;
        i_brightness <= val;
        mode_cnt[mode]++;
        do @(negedge i_clk); while (!item_taken);
    endtask

    // saturation/value: mostly uniform, sometimes right on a palette threshold
    function automatic logic [7:0] pick_level();
        logic [7:0] edges[14] = '{8'd0, 8'd1, 8'd37, 8'd38, 8'd101, 8'd102, 8'd114,
                                  8'd115, 8'd153, 8'd154, 8'd192, 8'd196, 8'd254,
                                  8'd255};
        if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 13)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_hue();
        int k;
        if ($urandom_range(0, 7) == 0) begin
            // straddle a sector boundary, wrapping at the full turn
            k = $urandom_range(0, 6) * SECTOR_STEP + $urandom_range(0, 4) - 2;
            return 16'(k);
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_random(int count);
        repeat (count) begin
            send_colour(t_mode'($urandom_range(0, 3)), pick_hue(),
                        16'($urandom_range(0, 65535)), pick_level(), pick_level());
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // plain: black, a full-saturation hue at the wrap, white, and each sector start
        send_colour(MODE_PLAIN, 16'h0000, 16'h0000, 8'd0, 8'd0);
        send_colour(MODE_PLAIN, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
        send_colour(MODE_PLAIN, 16'h1234, 16'h0000, 8'd0, 8'd255);
        send_colour(MODE_PLAIN, 16'd10922, 16'h0000, 8'd255, 8'd255);
        send_colour(MODE_PLAIN, 16'd10923, 16'h0000, 8'd200, 8'd180);
        send_colour(MODE_PLAIN, 16'd21846, 16'h0000, 8'd128, 8'd255);
        send_colour(MODE_PLAIN, 16'd32768, 16'h0000, 8'd255, 8'd100);
        send_colour(MODE_PLAIN, 16'd43691, 16'h0000, 8'd77, 8'd200);
        send_colour(MODE_PLAIN, 16'd54614, 16'h0000, 8'd255, 8'd255);
        // accent: saturation cap, value floor, shift wrapping past a full turn
        send_colour(MODE_ACCENT, 16'hFFFF, 16'hFFFF, 8'd255, 8'd0);
        send_colour(MODE_ACCENT, 16'h8000, 16'h8000, 8'd192, 8'd115);
        send_colour(MODE_ACCENT, 16'h0000, 16'h0001, 8'd191, 8'd114);
        send_colour(MODE_ACCENT, 16'h4000, 16'hC000, 8'd0, 8'd255);
        // belly: saturation floor, value cap
        send_colour(MODE_BELLY, 16'h0000, 16'hFFFF, 8'd0, 8'd255);
        send_colour(MODE_BELLY, 16'h2AAB, 16'h0000, 8'd101, 8'd195);
        send_colour(MODE_BELLY, 16'hD555, 16'h0000, 8'd102, 8'd196);
        send_colour(MODE_BELLY, 16'hFFFF, 16'h0000, 8'd255, 8'd0);
        // eye: value just on each side of the threshold, hue flipped half a turn
        send_colour(MODE_EYE, 16'h0000, 16'h0000, 8'd0, 8'd153);
        send_colour(MODE_EYE, 16'h8000, 16'hFFFF, 8'd255, 8'd154);
        send_colour(MODE_EYE, 16'hFFFF, 16'h0000, 8'd128, 8'd255);
        send_colour(MODE_EYE, 16'h7FFF, 16'h0000, 8'd255, 8'd0);

        for (int blk = 0; blk < 12; blk++) begin
            tx_gaps_on = $urandom_range(0, 3) != 0;
            send_random(50);
        end

        // sender pauses until the pipeline is empty
        wait_drained();
        repeat ($urandom_range(1, 8)) @(negedge i_clk);

        // long output stall with the sender pushing back-to-back
        rx_hold    = 1'b1;
        tx_gaps_on = 1'b0;
        send_random(40);

        for (int blk = 0; blk < 14; blk++) begin
            tx_gaps_on = $urandom_range(0, 3) != 0;
            send_random(50);
        end

        // last part at full rate on both sides
        quiet = 1'b1;
        send_random(150);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d plain, %0d accent, %0d belly, %0d eye items; %0d results compared",
                 mode_cnt[MODE_PLAIN], mode_cnt[MODE_ACCENT], mode_cnt[MODE_BELLY],
                 mode_cnt[MODE_EYE], checked);
        $display("Covered random stalls on both sides, a long output hold and a drain pause");
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
